>>> rtl/core/clex_pkg.sv
package clex_pkg;

    // source size limit and the saturation points that follow from it
    localparam int unsigned LP_MAX_SOURCE_BYTES = 65536;
    localparam logic [15:0] LP_POS_CAP = (LP_MAX_SOURCE_BYTES - 1 < 65535)
                                         ? 16'(LP_MAX_SOURCE_BYTES - 1) : 16'd65535;
    localparam logic [16:0] LP_LEN_CAP = (LP_MAX_SOURCE_BYTES < 65536)
                                         ? 17'(LP_MAX_SOURCE_BYTES) : 17'd65536;

    // token kinds
    localparam logic [3:0] K_KEYWORD = 4'd0;
    localparam logic [3:0] K_IDENT   = 4'd1;
    localparam logic [3:0] K_NUMBER  = 4'd2;
    localparam logic [3:0] K_LPAREN  = 4'd3;
    localparam logic [3:0] K_RPAREN  = 4'd4;
    localparam logic [3:0] K_LBRACE  = 4'd5;
    localparam logic [3:0] K_RBRACE  = 4'd6;
    localparam logic [3:0] K_EQUALS  = 4'd7;
    localparam logic [3:0] K_SEMI    = 4'd8;
    localparam logic [3:0] K_COMMA   = 4'd9;
    localparam logic [3:0] K_PREPROC = 4'd10;
    localparam logic [3:0] K_EOF     = 4'd11;
    localparam logic [3:0] K_UNKNOWN = 4'd12;

    // lexer modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NAME    = 3'd1;
    localparam logic [2:0] M_NUMBER  = 3'd2;
    localparam logic [2:0] M_PREPROC = 3'd3;
    localparam logic [2:0] M_COMMENT = 3'd4;
    localparam logic [2:0] M_STRING  = 3'd5;
    localparam logic [2:0] M_ESCAPE  = 3'd6;
    localparam logic [2:0] M_HELD    = 3'd7;

    // characters with a meaning of their own
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // keyword table, zero padded to eight columns
    localparam int unsigned LP_NUM_KW = 8;
    localparam logic [7:0] LP_KW_TEXT [0:7][0:7] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [2:0] LP_KW_LEN [0:7] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd5, 3'd2, 3'd4, 3'd6
    };

    // output queue
    localparam int unsigned LP_FIFO_DEPTH = 4;
    localparam int unsigned LP_PTR_W      = $clog2(LP_FIFO_DEPTH);

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_offset;
        logic [16:0] token_length;
        logic        last_of_run;
    } t_token;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'd48) && (b <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic logic [16:0] grow(input logic [16:0] len);
        return (len < LP_LEN_CAP) ? len + 17'd1 : len;
    endfunction

    // drop every keyword whose character at idx differs from b
    function automatic logic [7:0] kw_match(input logic [7:0] mask, input logic [16:0] idx,
                                            input logic [7:0] b);
        logic [7:0] m;
        m = mask;
        for (int k = 0; k < LP_NUM_KW; k++) begin
            if ((idx >= 17'(LP_KW_LEN[k])) || (LP_KW_TEXT[k][idx[2:0]] != b)) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] name_kind(input logic [7:0] mask, input logic [16:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < LP_NUM_KW; k++) begin
            if (mask[k] && (len == 17'(LP_KW_LEN[k]))) begin
                hit = 1'b1;
            end
        end
        return hit ? K_KEYWORD : K_IDENT;
    endfunction

    function automatic logic [3:0] held_kind(input logic [7:0] c);
        logic [3:0] kind;
        kind = K_UNKNOWN;
        if (c == CH_EQ) begin
            kind = K_EQUALS;
        end else if ((c == CH_LT) || (c == CH_GT)) begin
            kind = K_IDENT;
        end
        return kind;
    endfunction

endpackage

>>> rtl/core/clex_if.sv
interface clex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_marker;

    modport source (output valid, output source_byte, output end_marker, input ready);
    modport sink (input valid, input source_byte, input end_marker, output ready);
endinterface

interface clex_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [16:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

>>> rtl/core/c_like_token_lexer.sv
// channel   dir  payload                                                 transfer when
// i_src     in   source_byte[7:0], end_marker                           valid && ready
// o_tok     out  token_kind[3:0], start_offset[15:0], token_length[16:0], valid && ready
//                last_of_run
//
// one input byte per cycle while i_src.ready is high; each transfer yields zero, one or two
// tokens in that same cycle, written into a four-entry output queue
// a byte that closes an open token and starts another yields two tokens for the output
// port to drain, so the output port sets the sustained rate for such bytes
// i_rst_n is synchronous: it clears the lexer state and empties the queue
// i_src.ready drops while the queue has fewer than two free entries; o_tok holds its head
// entry while o_tok.ready is low
module c_like_token_lexer
    import clex_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    clex_in_if.sink           i_src,
    clex_out_if.source        o_tok
);

    localparam logic [LP_PTR_W:0] LP_READY_MAX = (LP_PTR_W + 1)'(LP_FIFO_DEPTH - 2);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_open_start, n_open_start;
    logic [16:0] r_open_length, n_open_length;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_kw_mask, n_kw_mask;
    logic [7:0]  r_pend, n_pend;

    t_token                r_fifo [LP_FIFO_DEPTH];
    logic [LP_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [LP_PTR_W:0]     r_count, n_count;

    logic        accept, pop, done;
    logic [7:0]  b;
    logic        a_v, b_v;
    logic [3:0]  a_kind, b_kind;
    logic [15:0] a_start, b_start;
    logic [16:0] a_len, b_len;
    logic [1:0]  push_cnt;
    t_token      tok_first, tok_second;

    assign accept = i_src.valid && i_src.ready;
    assign pop    = o_tok.valid && o_tok.ready;
    assign b      = i_src.source_byte;

    always_comb begin
        n_mode        = r_mode;
        n_open_start  = r_open_start;
        n_open_length = r_open_length;
        n_pos         = r_pos;
        n_kw_mask     = r_kw_mask;
        n_pend        = r_pend;
        a_v           = 1'b0;
        a_kind        = K_UNKNOWN;
        a_start       = r_open_start;
        a_len         = r_open_length;
        b_v           = 1'b0;
        b_kind        = K_UNKNOWN;
        b_start       = r_pos;
        b_len         = 17'd1;
        done          = 1'b0;

        if (i_src.end_marker) begin
            // flush whatever is open, then EOF, then back to reset state
            case (r_mode)
                M_NAME: begin
                    a_v    = 1'b1;
                    a_kind = name_kind(r_kw_mask, r_open_length);
                end
                M_NUMBER: begin
                    a_v    = 1'b1;
                    a_kind = K_NUMBER;
                end
                M_PREPROC: begin
                    a_v    = 1'b1;
                    a_kind = K_PREPROC;
                end
                M_STRING, M_ESCAPE: begin
                    a_v    = 1'b1;
                    a_kind = K_IDENT;
                end
                M_HELD: begin
                    a_v    = 1'b1;
                    a_kind = held_kind(r_pend);
                    a_len  = 17'd1;
                end
                default: begin
                    a_v = 1'b0;
                end
            endcase
            b_v           = 1'b1;
            b_kind        = K_EOF;
            b_len         = 17'd0;
            n_mode        = M_IDLE;
            n_open_start  = 16'd0;
            n_open_length = 17'd0;
            n_pos         = 16'd0;
            n_kw_mask     = 8'hFF;
            n_pend        = 8'd0;
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (b == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                    done = 1'b1;
                end
                M_PREPROC: begin
                    if (b == CH_NL) begin
                        a_v           = 1'b1;
                        a_kind        = K_PREPROC;
                        n_mode        = M_IDLE;
                        n_open_length = 17'd0;
                    end else begin
                        n_open_length = grow(r_open_length);
                    end
                    done = 1'b1;
                end
                M_STRING: begin
                    n_open_length = grow(r_open_length);
                    if (b == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else if (b == CH_QUOTE) begin
                        a_v           = 1'b1;
                        a_kind        = K_IDENT;
                        a_len         = grow(r_open_length);
                        n_mode        = M_IDLE;
                        n_open_length = 17'd0;
                    end
                    done = 1'b1;
                end
                M_ESCAPE: begin
                    n_open_length = grow(r_open_length);
                    n_mode        = M_STRING;
                    done          = 1'b1;
                end
                M_NAME: begin
                    if (is_name_char(b)) begin
                        n_kw_mask     = kw_match(r_kw_mask, r_open_length, b);
                        n_open_length = grow(r_open_length);
                        done          = 1'b1;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = name_kind(r_kw_mask, r_open_length);
                    end
                end
                M_NUMBER: begin
                    if (is_digit(b)) begin
                        n_open_length = grow(r_open_length);
                        done          = 1'b1;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = K_NUMBER;
                    end
                end
                M_HELD: begin
                    if ((r_pend == CH_SLASH) && (b == CH_SLASH)) begin
                        n_mode        = M_COMMENT;
                        n_open_length = 17'd0;
                        n_kw_mask     = 8'hFF;
                        n_pend        = 8'd0;
                        done          = 1'b1;
                    end else if ((r_pend != CH_SLASH) && (b == CH_EQ)) begin
                        // two-character relational operator
                        a_v           = 1'b1;
                        a_kind        = K_IDENT;
                        a_len         = 17'd2;
                        n_mode        = M_IDLE;
                        n_open_length = 17'd0;
                        n_kw_mask     = 8'hFF;
                        n_pend        = 8'd0;
                        done          = 1'b1;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = held_kind(r_pend);
                        a_len  = 17'd1;
                    end
                end
                default: begin
                    done = 1'b0;
                end
            endcase

            // the byte starts something new
            if (!done) begin
                n_mode        = M_IDLE;
                n_open_length = 17'd0;
                n_kw_mask     = 8'hFF;
                n_pend        = 8'd0;
                if (is_space(b)) begin
                    n_mode = M_IDLE;
                end else if ((b == CH_SLASH) || (b == CH_LT) || (b == CH_GT) ||
                             (b == CH_EQ) || (b == CH_BANG)) begin
                    n_mode       = M_HELD;
                    n_pend       = b;
                    n_open_start = r_pos;
                end else if (b == CH_HASH) begin
                    n_mode        = M_PREPROC;
                    n_open_start  = r_pos;
                    n_open_length = 17'd1;
                end else if (b == CH_LPAREN) begin
                    b_v    = 1'b1;
                    b_kind = K_LPAREN;
                end else if (b == CH_RPAREN) begin
                    b_v    = 1'b1;
                    b_kind = K_RPAREN;
                end else if (b == CH_LBRACE) begin
                    b_v    = 1'b1;
                    b_kind = K_LBRACE;
                end else if (b == CH_RBRACE) begin
                    b_v    = 1'b1;
                    b_kind = K_RBRACE;
                end else if (b == CH_SEMI) begin
                    b_v    = 1'b1;
                    b_kind = K_SEMI;
                end else if (b == CH_COMMA) begin
                    b_v    = 1'b1;
                    b_kind = K_COMMA;
                end else if (is_digit(b)) begin
                    n_mode        = M_NUMBER;
                    n_open_start  = r_pos;
                    n_open_length = 17'd1;
                end else if (is_alpha(b) || (b == CH_UNDER)) begin
                    n_mode        = M_NAME;
                    n_open_start  = r_pos;
                    n_kw_mask     = kw_match(8'hFF, 17'd0, b);
                    n_open_length = 17'd1;
                end else if (b == CH_QUOTE) begin
                    n_mode        = M_STRING;
                    n_open_start  = r_pos;
                    n_open_length = 17'd1;
                end else begin
                    b_v    = 1'b1;
                    b_kind = K_UNKNOWN;
                end
            end

            if (r_pos < LP_POS_CAP) begin
                n_pos = r_pos + 16'd1;
            end
        end
    end

    // pack the tokens of this byte in order, flag the final one
    always_comb begin
        push_cnt   = {1'b0, a_v} + {1'b0, b_v};
        tok_second = '{token_kind: b_kind, start_offset: b_start, token_length: b_len,
                       last_of_run: 1'b1};
        if (a_v) begin
            tok_first = '{token_kind: a_kind, start_offset: a_start, token_length: a_len,
                          last_of_run: !b_v};
        end else begin
            tok_first = tok_second;
        end
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = n_count + (LP_PTR_W + 1)'(push_cnt);
        end
        if (pop) begin
            n_count = n_count - (LP_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_IDLE;
            r_open_start  <= 16'd0;
            r_open_length <= 17'd0;
            r_pos         <= 16'd0;
            r_kw_mask     <= 8'hFF;
            r_pend        <= 8'd0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (accept) begin
                r_mode        <= n_mode;
                r_open_start  <= n_open_start;
                r_open_length <= n_open_length;
                r_pos         <= n_pos;
                r_kw_mask     <= n_kw_mask;
                r_pend        <= n_pend;
                r_wr_ptr      <= r_wr_ptr + LP_PTR_W'(push_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + LP_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (push_cnt != 2'd0)) begin
            r_fifo[r_wr_ptr] <= tok_first;
        end
        if (accept && (push_cnt == 2'd2)) begin
            r_fifo[r_wr_ptr + LP_PTR_W'(1)] <= tok_second;
        end
    end

    assign i_src.ready        = (r_count <= LP_READY_MAX);
    assign o_tok.valid        = (r_count != '0);
    assign o_tok.token_kind   = r_fifo[r_rd_ptr].token_kind;
    assign o_tok.start_offset = r_fifo[r_rd_ptr].start_offset;
    assign o_tok.token_length = r_fifo[r_rd_ptr].token_length;
    assign o_tok.last_of_run  = r_fifo[r_rd_ptr].last_of_run;

endmodule

>>> rtl/core/clex_chk.sv
module clex_chk
    import clex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_end_marker,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_out_kind,
    input  logic [15:0] i_out_start,
    input  logic [16:0] i_out_length,
    input  logic        i_out_last
);

    // queue comes out of reset empty
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("token output valid right after reset");

    // an end marker transfer always leaves at least the EOF token queued
    a_eof_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_end_marker) |=> i_out_valid)
        else $error("no token queued after end marker transfer");

    // EOF closes its run and carries no bytes
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == K_EOF)) |-> (i_out_last && (i_out_length == 17'd0)))
        else $error("EOF token with length or without last_of_run");

    // stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_kind) && $stable(i_out_start) &&
             $stable(i_out_length) && $stable(i_out_last)))
        else $error("token changed while stalled");

endmodule

bind c_like_token_lexer clex_chk u_clex_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_src.valid),
    .i_in_ready      (i_src.ready),
    .i_in_end_marker (i_src.end_marker),
    .i_out_valid     (o_tok.valid),
    .i_out_ready     (o_tok.ready),
    .i_out_kind      (o_tok.token_kind),
    .i_out_start     (o_tok.start_offset),
    .i_out_length    (o_tok.token_length),
    .i_out_last      (o_tok.last_of_run)
);
